/* rtl/core/mvt_pkg.sv */
// shared types and codes for the 4x4 matrix vector transform
package mvt_pkg;

  localparam int DIM = 4;
  localparam int EW  = 32;

  typedef logic signed [EW-1:0] elem_t;
  typedef elem_t [DIM-1:0] vec_t;
  typedef elem_t [DIM*DIM-1:0] matrix_t;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_LOAD  = 2'd0;
  localparam kind_t KIND_XFORM = 2'd1;
  localparam kind_t KIND_TRANS = 2'd2;

  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } pipe_ctrl_t;

endpackage

/* rtl/core/mvt_in_if.sv */
// input channel of the transform: command and four vector elements
interface mvt_in_if;
  logic                 valid;
  logic                 ready;
  mvt_pkg::kind_t       kind;
  logic [1:0]           column;
  logic [1:0]           row;
  mvt_pkg::elem_t       elem0;
  mvt_pkg::elem_t       elem1;
  mvt_pkg::elem_t       elem2;
  mvt_pkg::elem_t       elem3;

  modport source (output valid, kind, column, row, elem0, elem1, elem2, elem3,
                  input ready);
  modport sink (input valid, kind, column, row, elem0, elem1, elem2, elem3,
                output ready);
endinterface

/* rtl/core/mvt_out_if.sv */
// result channel of the transform: four result rows and a saturation flag
interface mvt_out_if;
  logic           valid;
  logic           ready;
  mvt_pkg::elem_t out0;
  mvt_pkg::elem_t out1;
  mvt_pkg::elem_t out2;
  mvt_pkg::elem_t out3;
  logic           clipped;

  modport source (output valid, out0, out1, out2, out3, clipped, input ready);
  modport sink (input valid, out0, out1, out2, out3, clipped, output ready);
endinterface

/* rtl/core/matrix4_vector_transform.sv */
// 4x4 Q16.16 matrix times vector transform, top level
// Takes one item per clock cycle unless back pressure stalls the input. Element loads and
// translation adds change the matrix at acceptance and give no result; the very next
// item already sees them. A transform item passes three register stages: the
// products of the sixteen 32x32 multipliers (four lanes of four, one per matrix
// element) are registered at acceptance, then each lane's four-way sum, then the
// output register after the floor shift and saturation, where its result is valid.
// Back pressure on the output stalls the pipeline stage by stage, so items keep
// flowing while any stage is free.
module matrix4_vector_transform #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  mvt_in_if.sink    in_ch,
  mvt_out_if.source out_ch
);

  localparam int SAT_W  = (ELEM_WIDTH < 16) ? 16 : ((ELEM_WIDTH > 32) ? 32 : ELEM_WIDTH);
  localparam int FRAC_W = (FRAC_BITS < 0) ? 0 : ((FRAC_BITS > 30) ? 30 : FRAC_BITS);

  logic                    v1_r;
  logic                    v2_r;
  logic                    ready1;
  logic                    ready2;
  logic                    out_free;
  logic                    in_acc;
  mvt_pkg::pipe_ctrl_t     ctrl;
  mvt_pkg::vec_t           vec;
  mvt_pkg::matrix_t        matrix;
  mvt_pkg::vec_t           lane_res;
  logic [mvt_pkg::DIM-1:0] lane_clip;

  assign out_free = !out_ch.valid || out_ch.ready;
  assign ready2   = !v2_r || out_free;
  assign ready1   = !v1_r || ready2;
  assign in_ch.ready = ready1;
  assign in_acc   = in_ch.valid && ready1;

  assign ctrl.s1_en = ready1;
  assign ctrl.s2_en = ready2;

  assign vec[0] = in_ch.elem0;
  assign vec[1] = in_ch.elem1;
  assign vec[2] = in_ch.elem2;
  assign vec[3] = in_ch.elem3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (ready1) begin
        v1_r <= in_ch.valid && (in_ch.kind == mvt_pkg::KIND_XFORM);
      end
      if (ready2) begin
        v2_r <= v1_r;
      end
    end
  end

  mvt_matrix u_matrix (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (in_acc),
    .kind   (in_ch.kind),
    .column (in_ch.column),
    .row    (in_ch.row),
    .vec    (vec),
    .matrix (matrix)
  );

  for (genvar r = 0; r < mvt_pkg::DIM; r++) begin : g_lane
    mvt_pkg::vec_t m_row;
    for (genvar c = 0; c < mvt_pkg::DIM; c++) begin : g_col
      assign m_row[c] = matrix[c*mvt_pkg::DIM + r];
    end
    mvt_lane #(
      .SAT_W  (SAT_W),
      .FRAC_W (FRAC_W)
    ) u_lane (
      .clk   (clk),
      .ctrl  (ctrl),
      .m_row (m_row),
      .vec   (vec),
      .res   (lane_res[r]),
      .clip  (lane_clip[r])
    );
  end

  mvt_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_en    (out_free),
    .pipe_valid (v2_r),
    .lane_res   (lane_res),
    .lane_clip  (lane_clip),
    .out_ch     (out_ch)
  );

  // a new result only comes from an item in the adder stage
  a_result_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(v2_r))
    else $error("result appeared without an item in the adder stage");

  // input stalls only when every stage holds an item
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (v1_r && v2_r && out_ch.valid && !out_ch.ready))
    else $error("input stalled with a free stage");

  // an element load lands in the store for the next item
  a_load_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.kind == mvt_pkg::KIND_LOAD) |=>
      matrix[$past({in_ch.column, in_ch.row})] == $past(in_ch.elem0))
    else $error("element load not stored");

endmodule

/* rtl/core/mvt_matrix.sv */
// matrix element store with element load and translation add
module mvt_matrix (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  mvt_pkg::kind_t   kind,
  input  logic [1:0]       column,
  input  logic [1:0]       row,
  input  mvt_pkg::vec_t    vec,
  output mvt_pkg::matrix_t matrix
);

  mvt_pkg::matrix_t matrix_r;
  mvt_pkg::matrix_t matrix_nxt;

  always_comb begin
    logic signed [mvt_pkg::EW:0] tsum;
    matrix_nxt = matrix_r;
    tsum = '0;
    if (wr_en) begin
      unique case (kind)
        mvt_pkg::KIND_LOAD: begin
          matrix_nxt[{column, row}] = vec[0];
        end
        mvt_pkg::KIND_TRANS: begin
          // translation column, rows x y z, saturating add
          for (int i = 0; i < 3; i++) begin
            tsum = {matrix_r[3*mvt_pkg::DIM+i][mvt_pkg::EW-1], matrix_r[3*mvt_pkg::DIM+i]}
                 + {vec[i][mvt_pkg::EW-1], vec[i]};
            if (tsum[mvt_pkg::EW] != tsum[mvt_pkg::EW-1]) begin
              matrix_nxt[3*mvt_pkg::DIM+i] = tsum[mvt_pkg::EW] ?
                {1'b1, {(mvt_pkg::EW-1){1'b0}}} : {1'b0, {(mvt_pkg::EW-1){1'b1}}};
            end else begin
              matrix_nxt[3*mvt_pkg::DIM+i] = tsum[mvt_pkg::EW-1:0];
            end
          end
        end
        default: begin
          matrix_nxt = matrix_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_r <= '0;
    end else begin
      matrix_r <= matrix_nxt;
    end
  end

  assign matrix = matrix_r;

endmodule

/* rtl/core/mvt_lane.sv */
// one result row: four products, their sum, then floor shift and saturation
module mvt_lane #(
  parameter int SAT_W  = 32,
  parameter int FRAC_W = 16
) (
  input  logic               clk,
  input  mvt_pkg::pipe_ctrl_t ctrl,
  input  mvt_pkg::vec_t      m_row,
  input  mvt_pkg::vec_t      vec,
  output mvt_pkg::elem_t     res,
  output logic               clip
);

  localparam int PW = 2 * mvt_pkg::EW;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< (SAT_W - 1)) - SW'(1);
  localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

  logic signed [PW-1:0] prod_r [mvt_pkg::DIM];
  logic signed [SW-1:0] sum_r;
  logic signed [SW-1:0] sum_nxt;
  logic signed [SW-1:0] shifted;

  always_ff @(posedge clk) begin
    if (ctrl.s1_en) begin
      for (int c = 0; c < mvt_pkg::DIM; c++) begin
        prod_r[c] <= $signed(m_row[c]) * $signed(vec[c]);
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int c = 0; c < mvt_pkg::DIM; c++) begin
      sum_nxt = sum_nxt + $signed({{2{prod_r[c][PW-1]}}, prod_r[c]});
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.s2_en) begin
      sum_r <= sum_nxt;
    end
  end

  // arithmetic shift rounds toward minus infinity
  assign shifted = sum_r >>> FRAC_W;

  always_comb begin
    if (shifted > MAXV) begin
      res  = MAXV[mvt_pkg::EW-1:0];
      clip = 1'b1;
    end else if (shifted < MINV) begin
      res  = MINV[mvt_pkg::EW-1:0];
      clip = 1'b1;
    end else begin
      res  = shifted[mvt_pkg::EW-1:0];
      clip = 1'b0;
    end
  end

endmodule

/* rtl/core/mvt_merge.sv */
// output register: gathers the four lane results and ors their clip flags
module mvt_merge (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load_en,
  input  logic            pipe_valid,
  input  mvt_pkg::vec_t   lane_res,
  input  logic [mvt_pkg::DIM-1:0] lane_clip,
  mvt_out_if.source       out_ch
);

  logic          valid_r;
  mvt_pkg::vec_t res_r;
  logic          clip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_en) begin
      valid_r <= pipe_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      res_r  <= lane_res;
      clip_r <= |lane_clip;
    end
  end

  assign out_ch.valid   = valid_r;
  assign out_ch.out0    = res_r[0];
  assign out_ch.out1    = res_r[1];
  assign out_ch.out2    = res_r[2];
  assign out_ch.out3    = res_r[3];
  assign out_ch.clipped = clip_r;

endmodule

/* tb/matrix4_vector_transform_tb.sv */
// testbench for the 4x4 matrix vector transform: directed cases and a random stream checked against a shadow matrix
`timescale 1ns / 100ps

module matrix4_vector_transform_tb;

  localparam int FRAC = 16;
  localparam int STALL_LIMIT = 2000;
  localparam mvt_pkg::kind_t KIND_NONE = 2'd3;
  localparam mvt_pkg::elem_t E_MAX = 32'sh7FFFFFFF;
  localparam mvt_pkg::elem_t E_MIN = 32'sh80000000;
  localparam mvt_pkg::elem_t E_ONE = 32'sh00010000;
  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

  typedef struct packed {
    mvt_pkg::kind_t kind;
    logic [1:0]     column;
    logic [1:0]     row;
    mvt_pkg::vec_t  elems;
  } cmd_t;

  typedef struct packed {
    mvt_pkg::vec_t rows;
    logic          clipped;
  } xform_res_t;

  logic clk = 1'b0;
  logic rst_n;

  mvt_in_if  in_ch ();
  mvt_out_if out_ch ();

  matrix4_vector_transform #(
    .ELEM_WIDTH(32),
    .FRAC_BITS (FRAC)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  mvt_pkg::elem_t matrix_shadow [mvt_pkg::DIM*mvt_pkg::DIM];
  cmd_t           cmd_q [$];
  xform_res_t     rows_due [$];

  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;
  logic quiet     = 1'b0;
  int   idle_odds = 6;
  int   send_gap  = 0;
  int   recv_gap  = 0;
  int   stall_cycles = 0;
  int   fail_count = 0;
  int   n_xform = 0, n_load = 0, n_trans = 0, n_none = 0, n_clipped = 0;

  // --- predictor ---

  function automatic xform_res_t transform_vector(mvt_pkg::vec_t v);
    xform_res_t res;
    logic signed [65:0] acc;
    mvt_pkg::elem_t a, b;
    res.clipped = 1'b0;
    for (int r = 0; r < mvt_pkg::DIM; r++) begin
      acc = '0;
      for (int c = 0; c < mvt_pkg::DIM; c++) begin
        a = matrix_shadow[c*mvt_pkg::DIM + r];
        b = v[c];
        acc = acc + a * b;
      end
      acc = acc >>> FRAC;
      if (acc > SAT_HI) begin
        res.rows[r] = E_MAX;
        res.clipped = 1'b1;
      end else if (acc < SAT_LO) begin
        res.rows[r] = E_MIN;
        res.clipped = 1'b1;
      end else begin
        res.rows[r] = acc[31:0];
      end
    end
    return res;
  endfunction

  function automatic void predict_command(cmd_t cmd);
    logic signed [32:0] sum;
    mvt_pkg::elem_t cur, off;
    case (cmd.kind)
      mvt_pkg::KIND_LOAD: begin
        matrix_shadow[cmd.column*mvt_pkg::DIM + cmd.row] = cmd.elems[0];
        n_load++;
      end
      mvt_pkg::KIND_TRANS: begin
        // translation column is column 3, rows 0..2, saturating
        for (int i = 0; i < 3; i++) begin
          cur = matrix_shadow[3*mvt_pkg::DIM + i];
          off = cmd.elems[i];
          sum = cur + off;
          if (sum > 33'sd2147483647) matrix_shadow[3*mvt_pkg::DIM + i] = E_MAX;
          else if (sum < -33'sd2147483648) matrix_shadow[3*mvt_pkg::DIM + i] = E_MIN;
          else matrix_shadow[3*mvt_pkg::DIM + i] = sum[31:0];
        end
        n_trans++;
      end
      mvt_pkg::KIND_XFORM: begin
        rows_due.push_back(transform_vector(cmd.elems));
        n_xform++;
      end
      default: n_none++;
    endcase
  endfunction

  // --- stimulus helpers ---

  function automatic void queue_cmd(mvt_pkg::kind_t k, logic [1:0] col, logic [1:0] row,
                                    mvt_pkg::elem_t e0, mvt_pkg::elem_t e1,
                                    mvt_pkg::elem_t e2, mvt_pkg::elem_t e3);
    cmd_t c;
    c.kind = k;
    c.column = col;
    c.row = row;
    c.elems = {e3, e2, e1, e0};
    cmd_q.push_back(c);
  endfunction

  function automatic mvt_pkg::elem_t pick_value(int span);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 5))
        0: return E_MAX;
        1: return E_MIN;
        2: return 32'sd0;
        3: return -32'sd1;
        4: return 32'sd1;
        default: return E_ONE;
      endcase
    end
    if (sel <= 2) return $urandom;
    return int'($urandom_range(0, 2*span)) - span;
  endfunction

  // n counts items that do something; unused kinds come on top
  task automatic queue_random(int n);
    int done, sel;
    done = 0;
    while (done < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        queue_cmd(mvt_pkg::KIND_LOAD, 2'($urandom), 2'($urandom), pick_value(1 << 18),
                  $urandom, $urandom, $urandom);
        done++;
      end else if (sel < 40) begin
        queue_cmd(mvt_pkg::KIND_TRANS, 2'($urandom), 2'($urandom), pick_value(1 << 18),
                  pick_value(1 << 18), pick_value(1 << 18), $urandom);
        done++;
      end else if (sel < 44) begin
        queue_cmd(KIND_NONE, 2'($urandom), 2'($urandom), $urandom, $urandom,
                  $urandom, $urandom);
      end else begin
        queue_cmd(mvt_pkg::KIND_XFORM, 2'($urandom), 2'($urandom), pick_value(1 << 22),
                  pick_value(1 << 22), pick_value(1 << 22), pick_value(1 << 22));
        done++;
      end
    end
  endtask

  // hold off until every queued item is in and every result is out
  task automatic drain();
    while (cmd_q.size() != 0 || in_ch.valid || rows_due.size() != 0)
      @(posedge clk);
  endtask

  // --- driver ---

  always @(negedge clk) begin
    logic v_nxt;
    if (in_taken) void'(cmd_q.pop_front());
    v_nxt = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && !in_taken) begin
        v_nxt = 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
      end else if (!quiet && $urandom_range(0, 99) < idle_odds) begin
        send_gap = $urandom_range(1, 19) - 1;
      end else if (cmd_q.size() > 0) begin
        v_nxt = 1'b1;
      end
    end
    in_ch.valid <= v_nxt;
    if (v_nxt) begin
      in_ch.kind   <= cmd_q[0].kind;
      in_ch.column <= cmd_q[0].column;
      in_ch.row    <= cmd_q[0].row;
      in_ch.elem0  <= cmd_q[0].elems[0];
      in_ch.elem1  <= cmd_q[0].elems[1];
      in_ch.elem2  <= cmd_q[0].elems[2];
      in_ch.elem3  <= cmd_q[0].elems[3];
    end
  end

  // result side back pressure
  always @(negedge clk) begin
    logic r_nxt;
    r_nxt = 1'b0;
    if (rst_n) begin
      if (recv_gap > 0) begin
        recv_gap--;
      end else if (!quiet && $urandom_range(0, 99) < idle_odds) begin
        recv_gap = $urandom_range(1, 19) - 1;
      end else begin
        r_nxt = 1'b1;
      end
    end
    out_ch.ready <= r_nxt;
  end

  // --- monitor and checker ---

  always @(posedge clk) begin
    xform_res_t want;
    mvt_pkg::vec_t got;
    cmd_t seen;
    in_taken  = rst_n && in_ch.valid && in_ch.ready;
    out_taken = rst_n && out_ch.valid && out_ch.ready;
    if (in_taken) begin
      seen.kind = in_ch.kind;
      seen.column = in_ch.column;
      seen.row = in_ch.row;
      seen.elems = {in_ch.elem3, in_ch.elem2, in_ch.elem1, in_ch.elem0};
      predict_command(seen);
    end
    if (out_taken) begin
      got = {out_ch.out3, out_ch.out2, out_ch.out1, out_ch.out0};
      if (rows_due.size() == 0) begin
        $error("result item with nothing expected: %h clipped %b", got, out_ch.clipped);
        fail_count++;
      end else begin
        want = rows_due.pop_front();
        for (int r = 0; r < mvt_pkg::DIM; r++) begin
          if (got[r] !== want.rows[r]) begin
            $error("out%0d mismatch: expected %0d, got %0d", r,
                   $signed(want.rows[r]), $signed(got[r]));
            fail_count++;
          end
        end
        if (out_ch.clipped !== want.clipped) begin
          $error("clipped mismatch: expected %0b, got %0b", want.clipped, out_ch.clipped);
          fail_count++;
        end
        if (want.clipped) n_clipped++;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || in_taken || out_taken) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles == STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // --- test sequence ---

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.kind   = mvt_pkg::KIND_LOAD;
    in_ch.column = '0;
    in_ch.row    = '0;
    in_ch.elem0  = '0;
    in_ch.elem1  = '0;
    in_ch.elem2  = '0;
    in_ch.elem3  = '0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero matrix after reset
    queue_cmd(mvt_pkg::KIND_XFORM, 2'd3, 2'd3, E_MAX, E_MIN, -32'sd1, 32'sd1);
    // identity, with junk in the unused operands
    for (int i = 0; i < mvt_pkg::DIM; i++)
      queue_cmd(mvt_pkg::KIND_LOAD, 2'(i), 2'(i), E_ONE, -32'sd1, E_MAX, E_MIN);
    queue_cmd(mvt_pkg::KIND_XFORM, 2'd1, 2'd2, E_MAX, E_MIN, 32'sd0, -32'sd1);
    queue_cmd(mvt_pkg::KIND_XFORM, 2'd0, 2'd0, -32'sd1, 32'sd1, E_ONE, E_MIN);
    // translation saturating both ways
    queue_cmd(mvt_pkg::KIND_TRANS, 2'd3, 2'd3, E_MAX, E_MIN, 32'sd1, -32'sd1);
    queue_cmd(mvt_pkg::KIND_TRANS, 2'd0, 2'd1, 32'sd1, -32'sd1, 32'sd0, E_MAX);
    queue_cmd(mvt_pkg::KIND_XFORM, 2'd2, 2'd0, 32'sd0, 32'sd0, 32'sd0, E_ONE);
    // unused kind must leave the matrix alone
    queue_cmd(KIND_NONE, 2'd3, 2'd3, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
    queue_cmd(mvt_pkg::KIND_XFORM, 2'd0, 2'd0, 32'sd0, 32'sd0, 32'sd0, E_ONE);
    // saturation of results, positive and negative
    queue_cmd(mvt_pkg::KIND_LOAD, 2'd0, 2'd0, E_MAX, 32'sd0, 32'sd0, 32'sd0);
    queue_cmd(mvt_pkg::KIND_LOAD, 2'd1, 2'd0, E_MAX, 32'sd0, 32'sd0, 32'sd0);
    queue_cmd(mvt_pkg::KIND_XFORM, 2'd0, 2'd0, E_MAX, E_MAX, 32'sd0, 32'sd0);
    queue_cmd(mvt_pkg::KIND_LOAD, 2'd0, 2'd0, E_MIN, 32'sd0, 32'sd0, 32'sd0);
    queue_cmd(mvt_pkg::KIND_LOAD, 2'd1, 2'd0, E_MIN, 32'sd0, 32'sd0, 32'sd0);
    queue_cmd(mvt_pkg::KIND_XFORM, 2'd0, 2'd0, E_MAX, E_MAX, 32'sd0, 32'sd0);
    queue_cmd(mvt_pkg::KIND_XFORM, 2'd0, 2'd0, E_MIN, E_MIN, 32'sd0, 32'sd0);
    // floor rounding of small negative sums
    queue_cmd(mvt_pkg::KIND_LOAD, 2'd3, 2'd3, 32'sd1, 32'sd0, 32'sd0, 32'sd0);
    queue_cmd(mvt_pkg::KIND_XFORM, 2'd0, 2'd0, 32'sd0, 32'sd0, 32'sd0, -32'sd1);
    queue_cmd(mvt_pkg::KIND_LOAD, 2'd2, 2'd1, -32'sd1, 32'sd0, 32'sd0, 32'sd0);
    queue_cmd(mvt_pkg::KIND_XFORM, 2'd3, 2'd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1);
    drain();

    idle_odds = 25;
    queue_random(600);
    drain();

    idle_odds = 4;
    queue_random(800);
    drain();

    // closing stretch at full rate
    quiet = 1'b1;
    queue_random(250);
    drain();
    repeat (8) @(posedge clk);

    $display("ran %0d transforms (%0d saturated), %0d element loads, %0d translations,",
             n_xform, n_clipped, n_load, n_trans);
    $display("%0d unused-kind items, with random stalls on both channels", n_none);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
